// ===== rtl/ptt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer table package
// Operation and status codes, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int MAX_TIMERS_DEF = 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_CHANGE = 2'd2;
    localparam logic [1:0] OP_RUN    = 2'd3;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EXPIRED   = 3'd3;
    localparam logic [2:0] ST_NONE_EXP  = 3'd4;

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_NEXT = 2'd1;
    localparam logic [1:0] SRC_PEND = 2'd2;

    typedef struct packed {
        logic       load;
        logic       rd_last;
        logic       idx_clr;
        logic       idx_inc;
        logic       wr_add;
        logic       wr_chg;
        logic       wr_del;
        logic       wr_rearm;
        logic       pend_set;
        logic       pend_clr;
        logic       emit;
        logic [2:0] emit_status;
        logic [1:0] emit_src;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       idx_end;
        logic       id_match;
        logic       expired;
        logic       pend_valid;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/ptt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer table controller
// Sequences add, search, delete, change and expiry scan steps over the
// datapath, one input transaction at a time.
// ----------------------------------------------------------------------------
module ptt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire ptt_pkg::t_sts i_sts,
    output ptt_pkg::t_cmd      o_cmd
);
    import ptt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_FIND = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_DRD  = 4'd4;
    localparam logic [3:0] S_DWR  = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_CHK  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.op == OP_ADD) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.emit_status = ST_FULL;
                            o_cmd.emit_src    = SRC_NONE;
                        end else begin
                            o_cmd.emit_status = ST_DONE;
                            o_cmd.emit_src    = SRC_NEXT;
                            o_cmd.wr_add      = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                end else if (i_sts.op == OP_RUN) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (i_sts.idx_end) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.emit_status = ST_NOT_FOUND;
                        o_cmd.emit_src    = SRC_NONE;
                        n_state           = S_IDLE;
                    end
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_sts.id_match) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_FIND;
                end else if (i_sts.op == OP_DELETE) begin
                    n_state = S_DRD;
                end else if (i_sts.out_free) begin
                    o_cmd.wr_chg      = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_status = ST_DONE;
                    o_cmd.emit_src    = SRC_NONE;
                    n_state           = S_IDLE;
                end
            end
            S_DRD: begin
                o_cmd.rd_last = 1'b1;
                n_state       = S_DWR;
            end
            S_DWR: begin
                o_cmd.rd_last = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.wr_del      = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_status = ST_DONE;
                    o_cmd.emit_src    = SRC_NONE;
                    n_state           = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.idx_end) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (!i_sts.expired) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN;
                end else if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.wr_rearm    = 1'b1;
                    o_cmd.pend_set    = 1'b1;
                    o_cmd.idx_inc     = 1'b1;
                    o_cmd.emit        = i_sts.pend_valid;
                    o_cmd.emit_last   = 1'b0;
                    o_cmd.emit_status = ST_EXPIRED;
                    o_cmd.emit_src    = SRC_PEND;
                    n_state           = S_SCAN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.pend_clr  = 1'b1;
                    if (i_sts.pend_valid) begin
                        o_cmd.emit_status = ST_EXPIRED;
                        o_cmd.emit_src    = SRC_PEND;
                    end else begin
                        o_cmd.emit_status = ST_NONE_EXP;
                        o_cmd.emit_src    = SRC_NONE;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/ptt_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer table datapath
// Timer memories, slot index, fill count, id counter, held expiry result and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module ptt_dpath #(
    parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [95:0]   i_s_tdata,
    input  wire logic [1:0]    i_s_tuser,
    input  wire ptt_pkg::t_cmd i_cmd,
    output ptt_pkg::t_sts      o_sts,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [31:0]        o_m_tdata,
    output logic [2:0]         o_m_tuser,
    output logic               o_m_tlast
);
    import ptt_pkg::*;

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);

    logic [31:0] mem_exp [MAX_TIMERS];
    logic [31:0] mem_per [MAX_TIMERS];
    logic [30:0] mem_id  [MAX_TIMERS];

    logic [1:0]       r_op;
    logic [31:0]      r_now;
    logic [31:0]      r_ivl;
    logic [31:0]      r_tgt;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;
    logic [30:0]      r_next_id;
    logic             r_pend_valid;
    logic [30:0]      r_pend_id;
    logic [31:0]      r_rd_exp;
    logic [31:0]      r_rd_per;
    logic [30:0]      r_rd_id;
    logic             r_out_valid;
    logic [2:0]       r_out_status;
    logic [31:0]      r_out_id;
    logic             r_out_last;

    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_exp;
    logic [31:0]      wr_per;
    logic [30:0]      wr_id;
    logic             we_exp;
    logic             we_per;
    logic             we_id;
    logic [31:0]      emit_id;
    logic             out_free;

    assign cnt_m1  = r_count - CNT_W'(1);
    assign rd_addr = i_cmd.rd_last ? cnt_m1[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign wr_addr = i_cmd.wr_add ? r_count[IDX_W-1:0] : r_idx[IDX_W-1:0];

    always_comb begin
        if (i_cmd.wr_del) begin
            wr_exp = r_rd_exp;
        end else if (i_cmd.wr_rearm) begin
            wr_exp = r_now + r_rd_per;
        end else begin
            wr_exp = r_now + r_ivl;
        end
        wr_per = i_cmd.wr_del ? r_rd_per : r_ivl;
        wr_id  = i_cmd.wr_del ? r_rd_id : r_next_id;
    end

    assign we_exp = i_cmd.wr_add | i_cmd.wr_chg | i_cmd.wr_del | i_cmd.wr_rearm;
    assign we_per = i_cmd.wr_add | i_cmd.wr_chg | i_cmd.wr_del;
    assign we_id  = i_cmd.wr_add | i_cmd.wr_del;

    always_ff @(posedge i_clk) begin
        if (we_exp) begin
            mem_exp[wr_addr] <= wr_exp;
        end
        if (we_per) begin
            mem_per[wr_addr] <= wr_per;
        end
        if (we_id) begin
            mem_id[wr_addr] <= wr_id;
        end
        r_rd_exp <= mem_exp[rd_addr];
        r_rd_per <= mem_per[rd_addr];
        r_rd_id  <= mem_id[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_s_tuser;
            r_now <= i_s_tdata[31:0];
            r_ivl <= i_s_tdata[63:32];
            r_tgt <= i_s_tdata[95:64];
        end
        if (i_cmd.pend_set) begin
            r_pend_id <= r_rd_id;
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_id     <= emit_id;
            r_out_last   <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_count      <= '0;
            r_next_id    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.wr_add) begin
                r_count   <= r_count + CNT_W'(1);
                r_next_id <= r_next_id + 31'd1;
            end else if (i_cmd.wr_del) begin
                r_count <= cnt_m1;
            end
            if (i_cmd.pend_set) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.pend_clr) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        case (i_cmd.emit_src)
            SRC_NEXT: emit_id = {1'b0, r_next_id};
            SRC_PEND: emit_id = {1'b0, r_pend_id};
            default:  emit_id = 32'hFFFF_FFFF;
        endcase
    end

    assign out_free = !r_out_valid || i_m_tready;

    assign o_sts.op         = r_op;
    assign o_sts.full       = r_count >= CNT_W'(MAX_TIMERS);
    assign o_sts.idx_end    = r_idx >= r_count;
    assign o_sts.id_match   = !r_tgt[31] && (r_rd_id == r_tgt[30:0]);
    assign o_sts.expired    = r_rd_exp <= r_now;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_id;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/periodic_timer_table_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer table unit
// Holds up to MAX_TIMERS periodic timers and serves add, delete, change and
// expiry scan requests, one input transaction at a time.
//
// The slave channel carries one request per transaction: the operation in
// tuser, the current time, the interval and the target id in tdata. The
// master channel returns results: status in tuser, timer id in tdata, and
// tlast on the final result of a request. A scan returns one result per
// expired timer in slot order, or a single none-expired result.
// An add answers from the dispatch state. Delete and change walk the slots
// through the find and compare states, and a delete on a match then reads
// the last slot and writes it over the matching one. A scan passes through
// the scan and check states for each active slot and ends in the finish
// state. The next request is taken in the cycle in which the last result
// first waits. Results leave through an output register, so the next
// request is taken while the last result waits. If the receiver stalls, the
// walk pauses at the next result it has to hand over; nothing is lost.
// Reset empties the table and restarts ids at zero; no clearing pass runs.
// ----------------------------------------------------------------------------
module periodic_timer_table_unit #(
    parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // now_ms [31:0], interval_ms [63:32], target_id [95:64]
    input  wire logic [95:0] i_s_tdata,
    // operation [1:0]
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // timer_id [31:0]
    output logic [31:0]      o_m_tdata,
    // status [2:0]
    output logic [2:0]       o_m_tuser,
    output logic             o_m_tlast
);
    import ptt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ptt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ptt_dpath #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("Result written while the output register was still full.");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.wr_add, cmd.wr_chg, cmd.wr_del, cmd.wr_rearm}))
        else $error("More than one table write in one cycle.");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !sts.pend_valid)
        else $error("Request accepted with an expired result still held.");

    a_last_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.emit_last) |=> !sts.pend_valid)
        else $error("Held expired result survived the final result.");

endmodule
`default_nettype wire

// ===== sim/periodic_timer_table_checker.sv =====
// ----------------------------------------------------------------------------
// Periodic timer table checker
// Watches the request and result channels of the timer table. Every accepted
// request is run through a behavioural copy of the table, which queues the
// results it should produce; every accepted result is compared field by
// field with the oldest queued one. The failure count and the number of
// results still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module periodic_timer_table_checker #(
    parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    // now_ms [31:0], interval_ms [63:32], target_id [95:64]
    input  wire logic [95:0] i_s_tdata,
    // operation [1:0]
    input  wire logic [1:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // timer_id [31:0]
    input  wire logic [31:0] i_m_tdata,
    // status [2:0]
    input  wire logic [2:0]  i_m_tuser,
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_pending
);
    import ptt_pkg::*;

    localparam logic [31:0] NO_ID = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] timer_id;
        logic        last;
    } t_reply;

    t_reply      awaited_replies[$];
    t_reply      want;
    t_reply      tail;
    logic [31:0] due_ms    [MAX_TIMERS];
    logic [31:0] period_ms [MAX_TIMERS];
    logic [30:0] slot_ids  [MAX_TIMERS];
    int          live_slots;
    logic [30:0] id_counter;
    int          fails;

    task automatic compute_replies(input logic [1:0] op, input logic [31:0] now,
                                   input logic [31:0] ivl, input logic [31:0] tid);
        int slot;
        int hits;
        int top;
        slot = -1;
        hits = 0;
        case (op) inside
            OP_ADD: begin
                if (live_slots >= MAX_TIMERS) begin
                    awaited_replies.push_back('{ST_FULL, NO_ID, 1'b1});
                end else begin
                    due_ms[live_slots]    = now + ivl;
                    period_ms[live_slots] = ivl;
                    slot_ids[live_slots]  = id_counter;
                    live_slots++;
                    awaited_replies.push_back('{ST_DONE, {1'b0, id_counter}, 1'b1});
                    id_counter = id_counter + 31'd1;
                end
            end
            OP_DELETE, OP_CHANGE: begin
                for (int i = 0; i < live_slots; i++) begin
                    if (slot < 0 && {1'b0, slot_ids[i]} == tid) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    awaited_replies.push_back('{ST_NOT_FOUND, NO_ID, 1'b1});
                end else begin
                    if (op == OP_DELETE) begin
                        top = live_slots - 1;
                        due_ms[slot]    = due_ms[top];
                        period_ms[slot] = period_ms[top];
                        slot_ids[slot]  = slot_ids[top];
                        live_slots      = top;
                    end else begin
                        due_ms[slot]    = now + ivl;
                        period_ms[slot] = ivl;
                    end
                    awaited_replies.push_back('{ST_DONE, NO_ID, 1'b1});
                end
            end
            default: begin
                for (int i = 0; i < live_slots; i++) begin
                    if (due_ms[i] <= now) begin
                        awaited_replies.push_back('{ST_EXPIRED, {1'b0, slot_ids[i]}, 1'b0});
                        due_ms[i] = now + period_ms[i];
                        hits++;
                    end
                end
                if (hits == 0) begin
                    awaited_replies.push_back('{ST_NONE_EXP, NO_ID, 1'b1});
                end else begin
                    tail = awaited_replies.pop_back();
                    tail.last = 1'b1;
                    awaited_replies.push_back(tail);
                end
            end
        endcase
    endtask

    initial begin
        fails      = 0;
        live_slots = 0;
        id_counter = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_replies.delete();
            live_slots = 0;
            id_counter = '0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_replies.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("Unexpected result: status %0d id %0d last %0b",
                                 i_m_tuser, $signed(i_m_tdata), i_m_tlast);
                    end
                end else begin
                    want = awaited_replies.pop_front();
                    if (want.status !== i_m_tuser || want.timer_id !== i_m_tdata ||
                        want.last !== i_m_tlast) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("Result mismatch: expected status %0d id %0d last %0b,",
                                     want.status, $signed(want.timer_id), want.last,
                                     " got status %0d id %0d last %0b",
                                     i_m_tuser, $signed(i_m_tdata), i_m_tlast);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                compute_replies(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32],
                                i_s_tdata[95:64]);
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_replies.size();
    end

endmodule

// ===== sim/periodic_timer_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Periodic timer table unit testbench
// Drives a directed run through the table's corner cases, then random
// requests with a drifting millisecond clock, under three flow-control
// regimes: slow receiver, slow sender, and no idling at all. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module periodic_timer_table_unit_tb;
    import ptt_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata    = '0;
    logic [1:0]  s_tuser    = OP_ADD;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          cycles     = 0;
    int          gap_pct    = 0;
    int          stall_pct  = 0;
    int          ids_issued = 0;
    logic [31:0] stim_now   = '0;

    periodic_timer_table_unit #(
        .MAX_TIMERS (MAX_TIMERS_DEF)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    periodic_timer_table_checker #(
        .MAX_TIMERS (MAX_TIMERS_DEF)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [31:0] now,
                                input logic [31:0] ivl, input logic [31:0] tid);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tid, ivl, now};
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (op == OP_ADD) ids_issued++;
    endtask

    // Targets mostly fall on recently issued ids so that deletes and changes
    // usually hit a live timer.
    task automatic send_random();
        int          pick;
        int          recent;
        logic [1:0]  op;
        logic [31:0] ivl;
        logic [31:0] tid;
        pick = $urandom_range(0, 99);
        if (pick < 30) op = OP_ADD;
        else if (pick < 50) op = OP_DELETE;
        else if (pick < 65) op = OP_CHANGE;
        else op = OP_RUN;
        if ($urandom_range(0, 9) == 0) stim_now = $urandom();
        else stim_now = stim_now + $urandom_range(0, 40);
        case ($urandom_range(0, 9))
            0: ivl = $urandom();
            1: ivl = '0;
            default: ivl = $urandom_range(1, 60);
        endcase
        recent = ids_issued - $urandom_range(1, 10);
        if (recent < 0) recent = 0;
        case ($urandom_range(0, 9))
            0: tid = $urandom();
            1: tid = '1;
            default: tid = recent;
        endcase
        send_request(op, stim_now, ivl, tid);
    endtask

    initial begin
        gap_pct   = 19;
        stall_pct = 67;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(OP_RUN,    32'd0,         32'd0,         32'd0);
        send_request(OP_DELETE, 32'd0,         32'd0,         32'd0);
        send_request(OP_ADD,    32'd0,         32'd0,         32'd0);
        send_request(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        for (int k = 0; k < 6; k++) begin
            send_request(OP_ADD, 32'd100, 32'd10 * k, 32'd0);
        end
        send_request(OP_ADD,    32'd200,       32'd5,         32'd0);
        send_request(OP_RUN,    32'hFFFF_FFFF, 32'd0,         32'd0);
        send_request(OP_CHANGE, 32'd0,         32'd1,         32'hFFFF_FFFF);
        send_request(OP_CHANGE, 32'd0,         32'd1,         32'h7FFF_FFFF);
        send_request(OP_DELETE, 32'd0,         32'd0,         32'h8000_0000);
        send_request(OP_CHANGE, 32'd5,         32'd10,        32'd3);
        send_request(OP_DELETE, 32'd0,         32'd0,         32'd0);
        send_request(OP_DELETE, 32'd0,         32'd0,         32'd7);
        send_request(OP_DELETE, 32'd0,         32'd0,         32'd0);
        send_request(OP_RUN,    32'd0,         32'd0,         32'd0);
        send_request(OP_RUN,    32'd15,        32'hAAAA_AAAA, 32'h5555_5555);
        send_request(OP_ADD,    32'h5555_5555, 32'hAAAA_AAAA, 32'd0);
        send_request(OP_RUN,    32'hFFFF_FFFE, 32'd0,         32'd0);

        repeat (135) send_random();
        gap_pct   = 67;
        stall_pct = 19;
        repeat (135) send_random();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (140) send_random();
        s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ptt_pkg.sv
rtl/ptt_ctrl.sv
rtl/ptt_dpath.sv
rtl/periodic_timer_table_unit.sv
sim/periodic_timer_table_checker.sv
sim/periodic_timer_table_unit_tb.sv
